// ===== rtl/core/rk45di_pkg.sv =====
// ----------------------------------------------------------------------------
// rk45di_pkg
// Types, widths and weight polynomial coefficients of the dense output unit.
// ----------------------------------------------------------------------------
package rk45di_pkg;

  localparam int THETA_W   = 17;
  localparam int DATA_W    = 32;
  localparam int LANES     = 6;
  localparam int HORNER    = 4;
  localparam int THETA_FB  = 16;
  localparam int WEIGHT_FB = 30;
  localparam int ACC_W     = 38;
  localparam int WGT_W     = 34;
  localparam int TERM_W    = 38;
  localparam int SUM_W     = 38;
  localparam int SPLIT     = 19;
  localparam int PP_W      = DATA_W + SPLIT;
  localparam int PROD_W    = DATA_W + SUM_W + 1;
  localparam int RES_W     = DATA_W + 3;
  localparam int QMAG_W    = DATA_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [THETA_W-1:0]        theta_t;
  typedef logic signed [DATA_W-1:0]  data_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [WGT_W-1:0]   wgt_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam theta_t THETA_ONE = theta_t'(1) << THETA_FB;
  localparam data_t  DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t  DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    theta_t                  theta;
    logic [DATA_W-1:0]       step_size;
    logic [DATA_W-1:0]       start_value;
    logic [LANES-1:0][DATA_W-1:0] slope;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } head_t;

  // Q.30 coefficients of theta^1..theta^4 for the weights of k1, k3..k7
  localparam acc_t COEF [LANES][HORNER] = '{
    '{ 38'sd1073741824, -38'sd3070230528,  38'sd3310703957, -38'sd1216348160 },
    '{ 38'sd0,           38'sd4341274221, -38'sd6753093233,  38'sd2894182814 },
    '{ 38'sd0,          -38'sd4194304000,  38'sd11184810667, -38'sd6291456000 },
    '{ 38'sd0,           38'sd2999956152, -38'sd7384507450,  38'sd4038402512 },
    '{ 38'sd0,          -38'sd1687308581,  38'sd3937053355, -38'sd2109135726 },
    '{ 38'sd0,           38'sd1610612736, -38'sd4294967296,  38'sd2684354560 }
  };

  // round(a * theta / 2^16), ties away from zero
  function automatic acc_t theta_mul(acc_t a, theta_t t);
    logic [ACC_W-1:0]         mag;
    logic [ACC_W+THETA_W-1:0] prod;
    logic [ACC_W-1:0]         res;
    mag  = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    prod = (ACC_W+THETA_W)'(mag) * (ACC_W+THETA_W)'(t)
         + ((ACC_W+THETA_W)'(1) << (THETA_FB - 1));
    res  = prod[ACC_W+THETA_FB-1:THETA_FB];
    return a[ACC_W-1] ? acc_t'(-res) : acc_t'(res);
  endfunction

  // round(w * k / 2^30), ties away from zero
  function automatic term_t weight_mul(wgt_t w, data_t k);
    logic [WGT_W-1:0]        wmag;
    logic [DATA_W-1:0]       kmag;
    logic [WGT_W+DATA_W-1:0] prod;
    logic [TERM_W-1:0]       res;
    wmag = w[WGT_W-1] ? WGT_W'(-w) : WGT_W'(w);
    kmag = k[DATA_W-1] ? DATA_W'(-k) : DATA_W'(k);
    prod = (WGT_W+DATA_W)'(wmag) * (WGT_W+DATA_W)'(kmag)
         + ((WGT_W+DATA_W)'(1) << (WEIGHT_FB - 1));
    res  = TERM_W'(prod[WGT_W+DATA_W-1:WEIGHT_FB]);
    return (w[WGT_W-1] ^ k[DATA_W-1]) ? term_t'(-res) : term_t'(res);
  endfunction

endpackage

// ===== rtl/core/rk45di_if.sv =====
// ----------------------------------------------------------------------------
// rk45di_if
// Valid/ready channels for input items and interpolated results.
// ----------------------------------------------------------------------------
interface rk45di_sample_if import rk45di_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [THETA_W-1:0]       fraction;
  logic signed [DATA_W-1:0] step_size;
  logic signed [DATA_W-1:0] start_value;
  logic signed [DATA_W-1:0] slope_one;
  logic signed [DATA_W-1:0] slope_three;
  logic signed [DATA_W-1:0] slope_four;
  logic signed [DATA_W-1:0] slope_five;
  logic signed [DATA_W-1:0] slope_six;
  logic signed [DATA_W-1:0] slope_seven;

  modport source (
    output valid, fraction, step_size, start_value, slope_one, slope_three,
           slope_four, slope_five, slope_six, slope_seven,
    input  ready
  );
  modport sink (
    input  valid, fraction, step_size, start_value, slope_one, slope_three,
           slope_four, slope_five, slope_six, slope_seven,
    output ready
  );
endinterface

interface rk45di_result_if import rk45di_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] interpolated;
  logic                     saturated;

  modport source (output valid, interpolated, saturated, input ready);
  modport sink   (input valid, interpolated, saturated, output ready);
endinterface

// ===== rtl/core/rk45_dense_output_interp_unit.sv =====
// ----------------------------------------------------------------------------
// rk45_dense_output_interp_unit
// Dormand-Prince dense output: y + h * sum(d_i(theta) * k_i), saturated.
// ----------------------------------------------------------------------------
// Channels: sample carries one state element per transfer (fraction theta in
// Q1.16, step size, start value and slopes k1, k3..k7, all Q16.16 for the
// default FRAC_BITS); result carries the interpolated value and a flag that
// is set when the value was clipped to the 32-bit range.
// Throughput: one transfer per cycle on both channels while result is not stalled.
// Path: the transfer edge loads the input register, the item is then written
// into the queue, and nine arithmetic stages follow: the Horner chain (four
// multiplies), the slope products, the sum, the split step product, its
// rounding with the range check, and the final add with saturation.
// Reset clears the input valid bit, the queue pointers and count, and all stage
// valid bits; no result is pending after reset.
// When result is stalled the arithmetic pipeline holds; the four-entry queue
// and the input register keep taking samples until they are full, then
// sample.ready drops.
// ----------------------------------------------------------------------------
module rk45_dense_output_interp_unit import rk45di_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  rk45di_sample_if.sink   sample,
  rk45di_result_if.source result
);

  push_t push;
  logic  push_ready;
  logic  pop;
  head_t head;

  rk45di_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .push_ready (push_ready),
    .push       (push)
  );

  rk45di_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head)
  );

  rk45di_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== rtl/core/rk45di_front.sv =====
// ----------------------------------------------------------------------------
// rk45di_front
// Input stage: accept an item, clamp the fraction to one, register for push.
// ----------------------------------------------------------------------------
module rk45di_front import rk45di_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  rk45di_sample_if.sink sample,
  input  logic          push_ready,
  output push_t         push
);

  logic   hold_valid;
  item_t  hold_item;
  item_t  item_next;

  assign sample.ready = !hold_valid || push_ready;

  always_comb begin
    item_next.theta       = (sample.fraction > THETA_ONE) ? THETA_ONE : sample.fraction;
    item_next.step_size   = sample.step_size;
    item_next.start_value = sample.start_value;
    item_next.slope[0]    = sample.slope_one;
    item_next.slope[1]    = sample.slope_three;
    item_next.slope[2]    = sample.slope_four;
    item_next.slope[3]    = sample.slope_five;
    item_next.slope[4]    = sample.slope_six;
    item_next.slope[5]    = sample.slope_seven;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sample.ready) begin
      hold_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      hold_item <= item_next;
    end
  end

  assign push.valid = hold_valid;
  assign push.item  = hold_item;

endmodule

// ===== rtl/core/rk45di_queue.sv =====
// ----------------------------------------------------------------------------
// rk45di_queue
// Short FIFO between the input stage and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module rk45di_queue import rk45di_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  push_ready,
  input  logic  pop,
  output head_t head
);

  item_t             entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push.item;
    end
  end

  assign head.avail = (count != '0);
  assign head.item  = entry[rd_ptr];

endmodule

// ===== rtl/core/rk45di_back.sv =====
// ----------------------------------------------------------------------------
// rk45di_back
// Arithmetic pipeline: Horner weights, weighted slope sum, step product,
// final add with saturation. The whole pipeline holds while the output stalls.
// ----------------------------------------------------------------------------
module rk45di_back import rk45di_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  head_t            head,
  output logic             pop,
  rk45di_result_if.source  result
);

  localparam int STAGES = 9;

  logic [STAGES-1:0] vld;
  logic              en;

  theta_t theta_pipe [3];
  acc_t   horner     [3][LANES];
  wgt_t   wgt        [LANES];
  term_t  term       [LANES];
  sum_t   sum;
  data_t  slope_pipe [4][LANES];
  data_t  h_pipe     [6];
  data_t  y_pipe     [8];

  logic [PP_W-1:0]   pp_lo;
  logic [PP_W-1:0]   pp_hi;
  logic              neg7;
  logic              neg8;
  logic              big;
  logic [QMAG_W-1:0] qmag;
  data_t             interpolated;
  logic              saturated;

  sum_t              sum_next;
  logic [DATA_W-1:0] h_mag;
  logic [SUM_W-1:0]  s_mag;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] shifted;
  logic signed [RES_W-1:0] res;

  assign en  = !vld[STAGES-1] || result.ready;
  assign pop = head.avail && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], pop};
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_next = sum_next + term[i];
    end
  end

  assign h_mag = h_pipe[5][DATA_W-1] ? DATA_W'(-h_pipe[5]) : DATA_W'(h_pipe[5]);
  assign s_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  assign prod = PROD_W'({pp_hi, {SPLIT{1'b0}}}) + PROD_W'(pp_lo)
              + (PROD_W'(1) << (FRAC_BITS - 1));
  assign shifted = prod >> FRAC_BITS;

  assign res = RES_W'(y_pipe[7])
             + (neg8 ? -$signed(RES_W'(qmag)) : $signed(RES_W'(qmag)));

  always_ff @(posedge clk) begin
    if (en) begin
      theta_pipe[0] <= head.item.theta;
      theta_pipe[1] <= theta_pipe[0];
      theta_pipe[2] <= theta_pipe[1];
      for (int i = 0; i < LANES; i++) begin
        horner[0][i] <= COEF[i][2] + theta_mul(COEF[i][3], head.item.theta);
        horner[1][i] <= COEF[i][1] + theta_mul(horner[0][i], theta_pipe[0]);
        horner[2][i] <= COEF[i][0] + theta_mul(horner[1][i], theta_pipe[1]);
        wgt[i]       <= WGT_W'(theta_mul(horner[2][i], theta_pipe[2]));
        term[i]      <= weight_mul(wgt[i], slope_pipe[3][i]);
        slope_pipe[0][i] <= head.item.slope[i];
        for (int s = 1; s < 4; s++) begin
          slope_pipe[s][i] <= slope_pipe[s-1][i];
        end
      end
      sum <= sum_next;

      h_pipe[0] <= head.item.step_size;
      for (int s = 1; s < 6; s++) begin
        h_pipe[s] <= h_pipe[s-1];
      end
      y_pipe[0] <= head.item.start_value;
      for (int s = 1; s < 8; s++) begin
        y_pipe[s] <= y_pipe[s-1];
      end

      pp_lo <= PP_W'(h_mag) * PP_W'(s_mag[SPLIT-1:0]);
      pp_hi <= PP_W'(h_mag) * PP_W'(s_mag[SUM_W-1:SPLIT]);
      neg7  <= h_pipe[5][DATA_W-1] ^ sum[SUM_W-1];

      big  <= |shifted[PROD_W-1:QMAG_W];
      qmag <= shifted[QMAG_W-1:0];
      neg8 <= neg7;

      if (big) begin
        interpolated <= neg8 ? DATA_MIN : DATA_MAX;
        saturated    <= 1'b1;
      end else if (res > RES_W'(DATA_MAX)) begin
        interpolated <= DATA_MAX;
        saturated    <= 1'b1;
      end else if (res < RES_W'(DATA_MIN)) begin
        interpolated <= DATA_MIN;
        saturated    <= 1'b1;
      end else begin
        interpolated <= res[DATA_W-1:0];
        saturated    <= 1'b0;
      end
    end
  end

  assign result.valid        = vld[STAGES-1];
  assign result.interpolated = interpolated;
  assign result.saturated    = saturated;

endmodule

// ===== rtl/core/rk45di_checker.sv =====
// ----------------------------------------------------------------------------
// rk45di_checker
// Port-level checks on the result channel of the dense output unit.
// ----------------------------------------------------------------------------
module rk45di_checker import rk45di_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input logic [DATA_W-1:0] interpolated,
  input logic              saturated
);

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    !rst && result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    !rst && result_valid && !result_ready |=> $stable(interpolated) && $stable(saturated))
    else $error("result payload changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      interpolated == DATA_MAX || interpolated == DATA_MIN)
    else $error("saturated result not at a range limit");

endmodule

bind rk45_dense_output_interp_unit rk45di_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .interpolated (result.interpolated),
  .saturated    (result.saturated)
);
